>>> rtl/bbct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbct_pkg
// Types and constants shared by the bounding box / cone transform pipeline.
// ----------------------------------------------------------------------------
package bbct_pkg;

  localparam int COORD_W    = 40;
  localparam int COEFF_FRAC = 14;
  localparam int COEFF_W    = COEFF_FRAC + 2;
  localparam int DIR_W      = 16;
  localparam int ANGLE_W    = 16;
  localparam int CODE_W     = 2;
  localparam int ROW_W      = 48;
  localparam int DIV_W      = 15;
  localparam int CFG_IDX_W  = 3;

  localparam int BPROD_W = COORD_W + COEFF_W;   // coordinate times coefficient
  localparam int DPROD_W = DIR_W + COEFF_W;     // direction times coefficient
  localparam int ACC_W   = BPROD_W + 3;         // three products plus translation
  localparam int QUO_W   = COORD_W;             // quotient bits kept before saturation
  localparam int QS_W    = QUO_W + 2;           // signed, saturated quotient

  localparam int FRONT_LAT = 3;
  localparam int LANE_LAT  = QUO_W + 3;
  localparam int PIPE_LAT  = FRONT_LAT + LANE_LAT;
  localparam int RESULT_LAT = PIPE_LAT + 2;     // accept edge to result edge

  localparam logic [CODE_W-1:0] CODE_VALID = 2'd0;

  // 50000.0 in Q24.16
  localparam logic signed [QS_W-1:0] INIT_BOUND = QS_W'(64'sd3276800000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X   = 3'd0,
    REG_ROW_Y   = 3'd1,
    REG_ROW_Z   = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5,
    REG_SCALE   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
    logic signed [DIR_W-1:0]   dir_x;
    logic signed [DIR_W-1:0]   dir_y;
    logic signed [DIR_W-1:0]   dir_z;
    logic [ANGLE_W-1:0]        cone_angle;
    logic [CODE_W-1:0]         box_code;
    logic [CODE_W-1:0]         cone_code;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] new_min_x;
    logic signed [COORD_W-1:0] new_min_y;
    logic signed [COORD_W-1:0] new_min_z;
    logic signed [COORD_W-1:0] new_max_x;
    logic signed [COORD_W-1:0] new_max_y;
    logic signed [COORD_W-1:0] new_max_z;
    logic signed [DIR_W-1:0]   new_dir_x;
    logic signed [DIR_W-1:0]   new_dir_y;
    logic signed [DIR_W-1:0]   new_dir_z;
    logic [ANGLE_W-1:0]        new_angle;
    logic [CODE_W-1:0]         new_box_code;
    logic [CODE_W-1:0]         new_cone_code;
  } out_item_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [QS_W-1:0] v);
    logic signed [QS_W-1:0] hi;
    logic signed [QS_W-1:0] lo;
    hi = QS_W'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - QS_W'(1);
    if (v > hi) return hi[COORD_W-1:0];
    if (v < lo) return lo[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

  function automatic logic signed [DIR_W-1:0] sat_dir(input logic signed [QS_W-1:0] v);
    logic signed [QS_W-1:0] hi;
    logic signed [QS_W-1:0] lo;
    hi = QS_W'({1'b0, {(DIR_W-1){1'b1}}});
    lo = -hi - QS_W'(1);
    if (v > hi) return hi[DIR_W-1:0];
    if (v < lo) return lo[DIR_W-1:0];
    return v[DIR_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/bbct_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbct_front
// Multiply and accumulate front end: per axis the smallest and largest
// transformed value over the box corners, and the rotated cone axis.
// ----------------------------------------------------------------------------
module bbct_front (
  input  wire logic                                         clk_i,
  input  wire bbct_pkg::in_item_t                           item_i,
  input  wire logic [2:0][bbct_pkg::ROW_W-1:0]              rows_i,
  input  wire logic [2:0][bbct_pkg::COORD_W-1:0]            shifts_i,
  output logic      [2:0][bbct_pkg::ACC_W-1:0]              min_acc_o,
  output logic      [2:0][bbct_pkg::ACC_W-1:0]              max_acc_o,
  output logic      [2:0][bbct_pkg::ACC_W-1:0]              dir_acc_o
);
  import bbct_pkg::*;

  logic signed [COORD_W-1:0] lo [3];
  logic signed [COORD_W-1:0] hi [3];
  logic signed [DIR_W-1:0]   dv [3];
  logic signed [COEFF_W-1:0] cf [3][3];

  logic signed [BPROD_W-1:0] plo_q [3][3];
  logic signed [BPROD_W-1:0] phi_q [3][3];
  logic signed [DPROD_W-1:0] pd_q  [3][3];

  logic signed [ACC_W-1:0] mn_a_d [3], mn_b_d [3], mx_a_d [3], mx_b_d [3];
  logic signed [ACC_W-1:0] mn_a_q [3], mn_b_q [3], mx_a_q [3], mx_b_q [3];
  logic signed [ACC_W-1:0] d_a_q [3], d_b_q [3];

  assign lo[0] = item_i.min_x;
  assign lo[1] = item_i.min_y;
  assign lo[2] = item_i.min_z;
  assign hi[0] = item_i.max_x;
  assign hi[1] = item_i.max_y;
  assign hi[2] = item_i.max_z;
  assign dv[0] = item_i.dir_x;
  assign dv[1] = item_i.dir_y;
  assign dv[2] = item_i.dir_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        cf[a][k] = rows_i[a][k*COEFF_W +: COEFF_W];
      end
    end
  end

  // products
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        plo_q[a][k] <= BPROD_W'(cf[a][k]) * BPROD_W'(lo[k]);
        phi_q[a][k] <= BPROD_W'(cf[a][k]) * BPROD_W'(hi[k]);
        pd_q[a][k]  <= DPROD_W'(cf[a][k]) * DPROD_W'(dv[k]);
      end
    end
  end

  // each term of the sum picks its own corner, so min/max split per term
  always_comb begin
    logic signed [BPROD_W-1:0] tmin [3];
    logic signed [BPROD_W-1:0] tmax [3];
    logic signed [ACC_W-1:0]   sh;
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        tmin[k] = (plo_q[a][k] < phi_q[a][k]) ? plo_q[a][k] : phi_q[a][k];
        tmax[k] = (plo_q[a][k] < phi_q[a][k]) ? phi_q[a][k] : plo_q[a][k];
      end
      sh = ACC_W'($signed(shifts_i[a])) <<< COEFF_FRAC;
      mn_a_d[a] = sh + ACC_W'(tmin[0]);
      mn_b_d[a] = ACC_W'(tmin[1]) + ACC_W'(tmin[2]);
      mx_a_d[a] = sh + ACC_W'(tmax[0]);
      mx_b_d[a] = ACC_W'(tmax[1]) + ACC_W'(tmax[2]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      mn_a_q[a] <= mn_a_d[a];
      mn_b_q[a] <= mn_b_d[a];
      mx_a_q[a] <= mx_a_d[a];
      mx_b_q[a] <= mx_b_d[a];
      d_a_q[a]  <= ACC_W'(pd_q[a][0]) + ACC_W'(pd_q[a][1]);
      d_b_q[a]  <= ACC_W'(pd_q[a][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      min_acc_o[a] <= mn_a_q[a] + mn_b_q[a];
      max_acc_o[a] <= mx_a_q[a] + mx_b_q[a];
      dir_acc_o[a] <= d_a_q[a] + d_b_q[a];
    end
  end

endmodule
`default_nettype wire

>>> rtl/bbct_div_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbct_div_lane
// Pipelined restoring divider, one quotient bit per stage. Truncates toward
// zero and clamps the quotient magnitude at 2^QUO_W.
// ----------------------------------------------------------------------------
module bbct_div_lane (
  input  wire logic                               clk_i,
  input  wire logic [bbct_pkg::DIV_W-1:0]         divisor_i,
  input  wire logic [bbct_pkg::ACC_W-1:0]         dividend_i,
  output logic      [bbct_pkg::QS_W-1:0]          quotient_o
);
  import bbct_pkg::*;

  localparam int REM_W = DIV_W + QUO_W;

  logic [ACC_W-1:0] mag_q;
  logic             neg0_q;

  logic [REM_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic             neg_q [QUO_W+1];
  logic             ovf_q [QUO_W+1];

  logic [QUO_W:0]   mag_fin;

  always_ff @(posedge clk_i) begin
    neg0_q <= dividend_i[ACC_W-1];
    mag_q  <= dividend_i[ACC_W-1] ? (~dividend_i + ACC_W'(1)) : dividend_i;
  end

  // magnitude at or above divisor * 2^QUO_W saturates anyway
  always_ff @(posedge clk_i) begin
    ovf_q[0] <= mag_q >= (ACC_W'(divisor_i) << QUO_W);
    rem_q[0] <= mag_q[REM_W-1:0];
    quo_q[0] <= '0;
    neg_q[0] <= neg0_q;
  end

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int B = QUO_W - 1 - s;
    logic [REM_W-1:0] trial;
    logic             take;
    assign trial = REM_W'(divisor_i) << B;
    assign take  = rem_q[s] >= trial;

    always_ff @(posedge clk_i) begin
      quo_q[s+1] <= take ? (quo_q[s] | (QUO_W'(1) << B)) : quo_q[s];
      neg_q[s+1] <= neg_q[s];
      ovf_q[s+1] <= ovf_q[s];
    end

    if (s < QUO_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[s+1] <= take ? (rem_q[s] - trial) : rem_q[s];
      end
    end
  end

  assign mag_fin = ovf_q[QUO_W] ? {1'b1, {QUO_W{1'b0}}} : {1'b0, quo_q[QUO_W]};

  always_ff @(posedge clk_i) begin
    quotient_o <= neg_q[QUO_W] ? (~QS_W'(mag_fin) + QS_W'(1)) : QS_W'(mag_fin);
  end

endmodule
`default_nettype wire

>>> rtl/bounding_box_cone_transform.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounding_box_cone_transform
// Affine transform of a patch bounding box and of its direction cone.
// ----------------------------------------------------------------------------
// Takes one item per clock: busy stays low, so an item is accepted whenever
// start is high. Each result is on result_o with strobe_o high for one cycle;
// the receiver must take it then. The divider lanes that divide the box
// bounds and cone axis by the scale register have 43 stages (magnitude,
// range check, 40 quotient bits, sign). The multiply/accumulate front end adds
// three stages, plus one input and one output register. Configuration writes
// are always ready and apply to items accepted after the write; write only
// while no item is in flight.
// ----------------------------------------------------------------------------
module bounding_box_cone_transform (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire bbct_pkg::in_item_t                   item_i,
  output logic                                      strobe_o,
  output bbct_pkg::out_item_t                       result_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [bbct_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [bbct_pkg::ROW_W-1:0]           cfg_data_i
);
  import bbct_pkg::*;

  logic [2:0][ROW_W-1:0]   rows_q;
  logic [2:0][COORD_W-1:0] shifts_q;
  logic [DIV_W-1:0]        scale_q;
  logic [DIV_W-1:0]        divisor;

  in_item_t it_q [PIPE_LAT+1];
  logic     v_q  [PIPE_LAT+1];

  logic [2:0][ACC_W-1:0] min_acc, max_acc, dir_acc;
  logic [QS_W-1:0]       qmin [3];
  logic [QS_W-1:0]       qmax [3];
  logic [QS_W-1:0]       qdir [3];

  out_item_t out_d, out_q;
  logic      strobe_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q[0] <= ROW_W'(1) << COEFF_FRAC;
      rows_q[1] <= ROW_W'(1) << (COEFF_FRAC + COEFF_W);
      rows_q[2] <= ROW_W'(1) << (COEFF_FRAC + 2 * COEFF_W);
      shifts_q  <= '0;
      scale_q   <= DIV_W'(1) << COEFF_FRAC;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ROW_X:   rows_q[0]   <= cfg_data_i;
        REG_ROW_Y:   rows_q[1]   <= cfg_data_i;
        REG_ROW_Z:   rows_q[2]   <= cfg_data_i;
        REG_SHIFT_X: shifts_q[0] <= cfg_data_i[COORD_W-1:0];
        REG_SHIFT_Y: shifts_q[1] <= cfg_data_i[COORD_W-1:0];
        REG_SHIFT_Z: shifts_q[2] <= cfg_data_i[COORD_W-1:0];
        REG_SCALE:   scale_q     <= cfg_data_i[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero scale acts as the smallest scale
  assign divisor = (scale_q == '0) ? DIV_W'(1) : scale_q;

  // item and valid travel alongside the arithmetic
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= PIPE_LAT; i++) v_q[i] <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      v_q[0] <= start && !busy;
      for (int i = 1; i <= PIPE_LAT; i++) v_q[i] <= v_q[i-1];
      strobe_q <= v_q[PIPE_LAT];
    end
  end

  always_ff @(posedge clk_i) begin
    it_q[0] <= item_i;
    for (int i = 1; i <= PIPE_LAT; i++) it_q[i] <= it_q[i-1];
  end

  bbct_front u_front (
    .clk_i     (clk_i),
    .item_i    (it_q[0]),
    .rows_i    (rows_q),
    .shifts_i  (shifts_q),
    .min_acc_o (min_acc),
    .max_acc_o (max_acc),
    .dir_acc_o (dir_acc)
  );

  for (genvar a = 0; a < 3; a++) begin : g_lane
    bbct_div_lane u_div_min (
      .clk_i      (clk_i),
      .divisor_i  (divisor),
      .dividend_i (min_acc[a]),
      .quotient_o (qmin[a])
    );
    bbct_div_lane u_div_max (
      .clk_i      (clk_i),
      .divisor_i  (divisor),
      .dividend_i (max_acc[a]),
      .quotient_o (qmax[a])
    );
    bbct_div_lane u_div_dir (
      .clk_i      (clk_i),
      .divisor_i  (divisor),
      .dividend_i (dir_acc[a]),
      .quotient_o (qdir[a])
    );
  end

  always_comb begin
    in_item_t                  it;
    logic signed [COORD_W-1:0] nmin [3];
    logic signed [COORD_W-1:0] nmax [3];
    logic signed [QS_W-1:0]    v;
    it = it_q[PIPE_LAT];
    for (int a = 0; a < 3; a++) begin
      v = $signed(qmin[a]);
      nmin[a] = sat_coord((v > INIT_BOUND) ? INIT_BOUND : v);
      v = $signed(qmax[a]);
      nmax[a] = sat_coord((v < -INIT_BOUND) ? -INIT_BOUND : v);
    end
    if (it.box_code == CODE_VALID) begin
      out_d.new_min_x = nmin[0];
      out_d.new_min_y = nmin[1];
      out_d.new_min_z = nmin[2];
      out_d.new_max_x = nmax[0];
      out_d.new_max_y = nmax[1];
      out_d.new_max_z = nmax[2];
    end else begin
      out_d.new_min_x = it.min_x;
      out_d.new_min_y = it.min_y;
      out_d.new_min_z = it.min_z;
      out_d.new_max_x = it.max_x;
      out_d.new_max_y = it.max_y;
      out_d.new_max_z = it.max_z;
    end
    if (it.cone_code == CODE_VALID) begin
      out_d.new_dir_x = sat_dir($signed(qdir[0]));
      out_d.new_dir_y = sat_dir($signed(qdir[1]));
      out_d.new_dir_z = sat_dir($signed(qdir[2]));
    end else begin
      out_d.new_dir_x = it.dir_x;
      out_d.new_dir_y = it.dir_y;
      out_d.new_dir_z = it.dir_z;
    end
    out_d.new_angle     = it.cone_angle;
    out_d.new_box_code  = it.box_code;
    out_d.new_cone_code = it.cone_code;
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign strobe_o = strobe_q;
  assign result_o = out_q;

endmodule
`default_nettype wire

>>> rtl/bbct_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbct_checker
// Port-level checks of the transform pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module bbct_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              start,
  input wire logic                              busy,
  input wire bbct_pkg::in_item_t                item_i,
  input wire logic                              strobe_o,
  input wire bbct_pkg::out_item_t               result_o
);
  import bbct_pkg::*;

  // every accepted item yields a result
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##RESULT_LAT strobe_o)
    else $error("accepted item produced no result");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(start && !busy, RESULT_LAT))
    else $error("result without an accepted item");

  a_side_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (result_o.new_angle == $past(item_i.cone_angle, RESULT_LAT) &&
                  result_o.new_box_code == $past(item_i.box_code, RESULT_LAT) &&
                  result_o.new_cone_code == $past(item_i.cone_code, RESULT_LAT)))
    else $error("angle or codes not echoed");

  a_box_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && result_o.new_box_code != CODE_VALID) |->
      (result_o.new_min_x == $past(item_i.min_x, RESULT_LAT) &&
       result_o.new_max_z == $past(item_i.max_z, RESULT_LAT)))
    else $error("invalid box not passed through");

endmodule

bind bounding_box_cone_transform bbct_checker u_bbct_checker (.*);
`default_nettype wire

>>> verif/bounding_box_cone_transform_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounding_box_cone_transform_test
// Self-checking bench: drives box/cone items and register writes, predicts
// every transformed box and cone in a scoreboard, and checks each strobe.
// ----------------------------------------------------------------------------
module bounding_box_cone_transform_test;
  import bbct_pkg::*;

  class bbox_scoreboard;
    logic [ROW_W-1:0]   rows[3];
    logic [COORD_W-1:0] shifts[3];
    logic [DIV_W-1:0]   scale;
    out_item_t          pending_boxes[$];
    int                 errors;

    function void reset_regs();
      rows[0] = 48'h0000_0000_4000;
      rows[1] = 48'h0000_4000_0000;
      rows[2] = 48'h4000_0000_0000;
      shifts[0] = '0;
      shifts[1] = '0;
      shifts[2] = '0;
      scale = 15'd16384;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [ROW_W-1:0] d);
      case (idx)
        REG_ROW_X:   rows[0] = d;
        REG_ROW_Y:   rows[1] = d;
        REG_ROW_Z:   rows[2] = d;
        REG_SHIFT_X: shifts[0] = d[COORD_W-1:0];
        REG_SHIFT_Y: shifts[1] = d[COORD_W-1:0];
        REG_SHIFT_Z: shifts[2] = d[COORD_W-1:0];
        REG_SCALE:   scale = d[DIV_W-1:0];
        default: ;
      endcase
    endfunction

    function longint coef(int a, int k);
      logic signed [COEFF_W-1:0] c;
      c = rows[a][k*COEFF_W +: COEFF_W];
      return longint'(c);
    endfunction

    function longint clip(longint v, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function out_item_t transform(in_item_t it);
      out_item_t r;
      longint lo[3], hi[3], p[3], nmin[3], nmax[3], d[3];
      longint dv, acc, q;
      logic signed [COORD_W-1:0] sh;
      logic signed [COORD_W-1:0] tmin[3], tmax[3];
      logic signed [DIR_W-1:0]   td[3];
      dv = (scale == 0) ? 1 : longint'(scale);
      lo[0] = longint'(it.min_x); lo[1] = longint'(it.min_y); lo[2] = longint'(it.min_z);
      hi[0] = longint'(it.max_x); hi[1] = longint'(it.max_y); hi[2] = longint'(it.max_z);
      d[0] = longint'(it.dir_x); d[1] = longint'(it.dir_y); d[2] = longint'(it.dir_z);
      for (int a = 0; a < 3; a++) begin
        nmin[a] = 64'sd3276800000;
        nmax[a] = -64'sd3276800000;
      end
      for (int c = 0; c < 8; c++) begin
        for (int k = 0; k < 3; k++) p[k] = c[k] ? hi[k] : lo[k];
        for (int a = 0; a < 3; a++) begin
          sh = shifts[a];
          acc = longint'(sh) * 16384;
          for (int k = 0; k < 3; k++) acc += coef(a, k) * p[k];
          q = acc / dv;
          if (q < nmin[a]) nmin[a] = q;
          if (q > nmax[a]) nmax[a] = q;
        end
      end
      for (int a = 0; a < 3; a++) begin
        tmin[a] = COORD_W'(clip(nmin[a], COORD_W));
        tmax[a] = COORD_W'(clip(nmax[a], COORD_W));
        acc = 0;
        for (int k = 0; k < 3; k++) acc += coef(a, k) * d[k];
        td[a] = DIR_W'(clip(acc / dv, DIR_W));
      end
      if (it.box_code == CODE_VALID) begin
        r.new_min_x = tmin[0]; r.new_min_y = tmin[1]; r.new_min_z = tmin[2];
        r.new_max_x = tmax[0]; r.new_max_y = tmax[1]; r.new_max_z = tmax[2];
      end else begin
        r.new_min_x = it.min_x; r.new_min_y = it.min_y; r.new_min_z = it.min_z;
        r.new_max_x = it.max_x; r.new_max_y = it.max_y; r.new_max_z = it.max_z;
      end
      if (it.cone_code == CODE_VALID) begin
        r.new_dir_x = td[0]; r.new_dir_y = td[1]; r.new_dir_z = td[2];
      end else begin
        r.new_dir_x = it.dir_x; r.new_dir_y = it.dir_y; r.new_dir_z = it.dir_z;
      end
      r.new_angle = it.cone_angle;
      r.new_box_code = it.box_code;
      r.new_cone_code = it.cone_code;
      return r;
    endfunction

    function void note_item(in_item_t it);
      pending_boxes.push_back(transform(it));
    endfunction

    function void cmp(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $display("%0t mismatch %s: expected %h actual %h", $realtime, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(out_item_t a);
      out_item_t e;
      if (pending_boxes.size() == 0) begin
        $display("%0t unexpected result %h", $realtime, a);
        errors++;
        return;
      end
      e = pending_boxes.pop_front();
      cmp("new_min_x", 64'(e.new_min_x), 64'(a.new_min_x));
      cmp("new_min_y", 64'(e.new_min_y), 64'(a.new_min_y));
      cmp("new_min_z", 64'(e.new_min_z), 64'(a.new_min_z));
      cmp("new_max_x", 64'(e.new_max_x), 64'(a.new_max_x));
      cmp("new_max_y", 64'(e.new_max_y), 64'(a.new_max_y));
      cmp("new_max_z", 64'(e.new_max_z), 64'(a.new_max_z));
      cmp("new_dir_x", 64'(e.new_dir_x), 64'(a.new_dir_x));
      cmp("new_dir_y", 64'(e.new_dir_y), 64'(a.new_dir_y));
      cmp("new_dir_z", 64'(e.new_dir_z), 64'(a.new_dir_z));
      cmp("new_angle", 64'(e.new_angle), 64'(a.new_angle));
      cmp("new_box_code", 64'(e.new_box_code), 64'(a.new_box_code));
      cmp("new_cone_code", 64'(e.new_cone_code), 64'(a.new_cone_code));
    endfunction
  endclass

  localparam int STALL_LIMIT = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t item_i = '0;
  logic strobe_o;
  out_item_t result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ROW_W-1:0] cfg_data_i = '0;

  bbox_scoreboard sb = new();
  int idle_cycles = 0;
  bit no_gaps;

  bounding_box_cone_transform uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .strobe_o(strobe_o), .result_o(result_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // scoreboard taps and stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_item(item_i);
      if (strobe_o) sb.check_result(result_o);
      if ((start && !busy) || strobe_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (no_gaps || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  task automatic send_item(in_item_t it);
    int g;
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [ROW_W-1:0] d);
    start <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, d);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for a clock edge first so the last accepted item is in the scoreboard
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_boxes.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [COORD_W-1:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return COORD_W'(rnd64());
      1: return COORD_W'($signed(rnd64()) >>> 40);
      2: return COORD_W'($signed(rnd64()) >>> 30);
      default: return COORD_W'($signed(rnd64()) >>> 48);
    endcase
  endfunction

  function automatic in_item_t rnd_item();
    in_item_t it;
    it.min_x = rnd_coord(); it.min_y = rnd_coord(); it.min_z = rnd_coord();
    it.max_x = rnd_coord(); it.max_y = rnd_coord(); it.max_z = rnd_coord();
    it.dir_x = DIR_W'($urandom); it.dir_y = DIR_W'($urandom); it.dir_z = DIR_W'($urandom);
    it.cone_angle = ANGLE_W'($urandom);
    it.box_code = ($urandom_range(0, 3) != 0) ? CODE_VALID : CODE_W'($urandom);
    it.cone_code = ($urandom_range(0, 3) != 0) ? CODE_VALID : CODE_W'($urandom);
    return it;
  endfunction

  task automatic load_matrix(logic [ROW_W-1:0] rx, logic [ROW_W-1:0] ry,
                             logic [ROW_W-1:0] rz, logic [ROW_W-1:0] tx,
                             logic [ROW_W-1:0] ty, logic [ROW_W-1:0] tz,
                             logic [ROW_W-1:0] sc);
    drain();
    write_reg(REG_ROW_X, rx);
    write_reg(REG_ROW_Y, ry);
    write_reg(REG_ROW_Z, rz);
    write_reg(REG_SHIFT_X, tx);
    write_reg(REG_SHIFT_Y, ty);
    write_reg(REG_SHIFT_Z, tz);
    write_reg(REG_SCALE, sc);
  endtask

  task automatic random_burst(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 16 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_item(rnd_item());
    end
    no_gaps = 0;
  endtask

  initial begin
    in_item_t it;
    localparam logic [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
    sb.reset_regs();
    no_gaps = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items under the reset matrix
    for (int b = 0; b < 4; b++) begin
      for (int c = 0; c < 4; c++) begin
        it = rnd_item();
        it.box_code = CODE_W'(b);
        it.cone_code = CODE_W'(c);
        send_item(it);
      end
    end
    it = '0;
    send_item(it);
    it = '1;
    it.box_code = CODE_VALID; it.cone_code = CODE_VALID;
    send_item(it);
    it = '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 16'sh7fff, 16'sh7fff, 16'sh7fff,
           16'hffff, CODE_VALID, CODE_VALID};
    send_item(it);
    it = '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 16'sh8000, 16'sh8000, 16'sh8000,
           16'h0000, CODE_VALID, CODE_VALID};
    send_item(it);
    // min above max, and a small box inside the init bounds
    it = '{CMAX, 40'sd100, -40'sd5, CMIN, -40'sd100, 40'sd5, 16'sd16384, -16'sd1,
           16'sd0, 16'h1234, CODE_VALID, CODE_VALID};
    send_item(it);
    it = '{-40'sd65536, -40'sd65536, -40'sd65536, 40'sd65536, 40'sd65536, 40'sd65536,
           16'sd1, 16'sd2, 16'sd3, 16'h0001, CODE_VALID, CODE_VALID};
    send_item(it);
    random_burst(30);

    // largest coefficients, largest shifts, smallest scale
    load_matrix(48'h7fff_7fff_7fff, 48'h8000_8000_8000, 48'h7fff_8000_0001,
                {8'h00, CMAX}, {8'hff, CMIN}, {8'h00, CMAX}, 48'd1);
    random_burst(45);
    // zero scale counts as one
    load_matrix(48'h8000_8000_8000, 48'h7fff_7fff_7fff, 48'h0000_0000_0000,
                {8'hff, CMIN}, {8'h00, CMAX}, {8'hff, CMIN}, 48'd0);
    random_burst(45);
    // largest scale with identity
    load_matrix(48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000,
                48'd0, 48'd0, 48'd0, 48'h7fff);
    random_burst(45);
    for (int ph = 0; ph < 5; ph++) begin
      load_matrix(ROW_W'(rnd64()), ROW_W'(rnd64()), ROW_W'(rnd64()),
                  ROW_W'(rnd64()), ROW_W'(rnd64()), ROW_W'(rnd64()),
                  ($urandom_range(0, 1) != 0) ? ROW_W'(rnd64())
                                              : ROW_W'($urandom_range(8192, 32767)));
      random_burst(45);
    end

    drain();
    repeat (RESULT_LAT + 20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_boxes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
